### rtl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants for the ray/segment tree query block
// Sizes, codes, queue item layout and multiplier interface types.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned IDX_W       = 14;
  localparam int unsigned FRAC_W      = 17;
  localparam int unsigned MODE_W      = 2;

  localparam int unsigned MAX_NODES   = 16384;
  localparam int unsigned MAX_LINES   = 8192;
  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned NODE_AW     = $clog2(MAX_NODES);
  localparam int unsigned LINE_AW     = $clog2(MAX_LINES);
  localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VISIT_LIMIT = 4 * MAX_NODES;
  localparam int unsigned VIS_W       = $clog2(VISIT_LIMIT + 1);

  localparam int unsigned NODE_DW     = 4 * COORD_W + 3 * IDX_W;
  localparam int unsigned SEG_DW      = 4 * COORD_W;

  localparam int unsigned OPW         = 35;
  localparam int unsigned HALF_W      = 18;
  localparam int unsigned PW          = 72;
  localparam int unsigned REM_W       = PW + 1;
  localparam int unsigned Q_W         = 16;
  localparam int unsigned QCNT_W      = $clog2(Q_W);
  localparam int unsigned NPROD       = 6;
  localparam int unsigned PIDX_W      = $clog2(NPROD);

  localparam int unsigned QD          = 2;
  localparam int unsigned QPTR_W      = $clog2(QD);
  localparam int unsigned QFILL_W     = $clog2(QD + 1);

  localparam logic [FRAC_W-1:0] NO_HIT = FRAC_W'(1 << Q_W);
  localparam logic [IDX_W-1:0]  NO_LINE = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_NODE  = 2'd0,
    MODE_SEG   = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NODE,
    KIND_SEG,
    KIND_QUERY,
    KIND_SHORT
  } kind_e;

  typedef struct packed {
    kind_e                      kind;
    logic [IDX_W-1:0]           slot;
    logic signed [COORD_W-1:0]  a_x;
    logic signed [COORD_W-1:0]  a_y;
    logic signed [COORD_W-1:0]  b_x;
    logic signed [COORD_W-1:0]  b_y;
    logic [IDX_W-1:0]           left_child;
    logic [IDX_W-1:0]           right_child;
    logic signed [IDX_W-1:0]    leaf_line;
    logic signed [COORD_W:0]    w_x;
    logic signed [COORD_W:0]    w_y;
  } item_t;

  typedef struct packed {
    logic                  start;
    logic signed [OPW-1:0] a;
    logic signed [OPW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [PW-1:0] p;
  } mul_rsp_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_LO,
    MUL_HI,
    MUL_SIGN
  } mul_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NODE_RD,
    BK_BOX_AXIS,
    BK_BOX_CMP,
    BK_BOX_MUL,
    BK_BOX_DEC,
    BK_SEG_PREP,
    BK_SEG_MUL,
    BK_SEG_SUB,
    BK_SEG_CHK,
    BK_DIV,
    BK_POP,
    BK_RESULT
  } back_state_e;

endpackage

### rtl/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module aabb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/aabb_mul.sv
// ----------------------------------------------------------------------------
// aabb_mul: shared signed multiplier
// Multiplies two signed operands in two partial-product passes, then signs.
// ----------------------------------------------------------------------------
module aabb_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aabb_pkg::mul_req_t req_i,
  output aabb_pkg::mul_rsp_t rsp_o
);
  import aabb_pkg::*;

  mul_state_e               state_q, state_d;
  logic [OPW-1:0]           amag_q;
  logic [2*HALF_W-1:0]      bmag_q;
  logic                     neg_q;
  logic [PW-1:0]            acc_q;
  logic [HALF_W-1:0]        chunk;
  logic [OPW+HALF_W-1:0]    part;
  logic signed [OPW-1:0]    a_neg, b_neg;

  assign a_neg = -req_i.a;
  assign b_neg = -req_i.b;
  assign chunk = (state_q == MUL_HI) ? bmag_q[2*HALF_W-1:HALF_W] : bmag_q[HALF_W-1:0];
  assign part  = amag_q * chunk;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      MUL_IDLE: if (req_i.start) state_d = MUL_LO;
      MUL_LO:   state_d = MUL_HI;
      MUL_HI:   state_d = MUL_SIGN;
      MUL_SIGN: state_d = MUL_IDLE;
      default:  state_d = MUL_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done = (state_q == MUL_SIGN);
    rsp_o.p    = neg_q ? -$signed(acc_q) : $signed(acc_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MUL_IDLE: begin
        if (req_i.start) begin
          amag_q <= req_i.a[OPW-1] ? $unsigned(a_neg) : $unsigned(req_i.a);
          bmag_q <= (2*HALF_W)'(req_i.b[OPW-1] ? $unsigned(b_neg) : $unsigned(req_i.b));
          neg_q  <= req_i.a[OPW-1] ^ req_i.b[OPW-1];
        end
      end
      MUL_LO:  acc_q <= PW'(part);
      MUL_HI:  acc_q <= acc_q + (PW'(part) << HALF_W);
      default: ;
    endcase
  end

endmodule

### rtl/aabb_front.sv
// ----------------------------------------------------------------------------
// aabb_front: input side of the query block
// Accepts transactions, drops ones with no effect, flags short rays, and
// holds classified items in a small queue for the traversal engine.
// ----------------------------------------------------------------------------
module aabb_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push_i,
  output logic                                 full_o,
  input  logic [aabb_pkg::MODE_W-1:0]          mode_i,
  input  logic [aabb_pkg::IDX_W-1:0]           slot_i,
  input  logic signed [aabb_pkg::COORD_W-1:0]  a_x_i,
  input  logic signed [aabb_pkg::COORD_W-1:0]  a_y_i,
  input  logic signed [aabb_pkg::COORD_W-1:0]  b_x_i,
  input  logic signed [aabb_pkg::COORD_W-1:0]  b_y_i,
  input  logic [aabb_pkg::IDX_W-1:0]           left_child_i,
  input  logic [aabb_pkg::IDX_W-1:0]           right_child_i,
  input  logic signed [aabb_pkg::IDX_W-1:0]    leaf_line_i,
  output logic                                 q_valid_o,
  output aabb_pkg::item_t                      q_item_o,
  input  logic                                 q_ready_i
);
  import aabb_pkg::*;

  item_t                entry_q [QD];
  logic [QPTR_W-1:0]    wptr_q, rptr_q;
  logic [QFILL_W-1:0]   fill_q;
  item_t                item;
  logic signed [COORD_W:0] w_x, w_y, nw_x, nw_y;
  logic [COORD_W:0]     mag_x, mag_y;
  logic [2*Q_W-1:0]     sq_x, sq_y;
  logic [2*Q_W:0]       sq_sum;
  logic                 is_short, keep, accept, enq, deq;
  mode_e                mode;

  assign mode = mode_e'(mode_i);
  assign w_x  = $signed({b_x_i[COORD_W-1], b_x_i}) - $signed({a_x_i[COORD_W-1], a_x_i});
  assign w_y  = $signed({b_y_i[COORD_W-1], b_y_i}) - $signed({a_y_i[COORD_W-1], a_y_i});
  assign nw_x = -w_x;
  assign nw_y = -w_y;
  assign mag_x = w_x[COORD_W] ? $unsigned(nw_x) : $unsigned(w_x);
  assign mag_y = w_y[COORD_W] ? $unsigned(nw_y) : $unsigned(w_y);
  assign sq_x  = mag_x[Q_W-1:0] * mag_x[Q_W-1:0];
  assign sq_y  = mag_y[Q_W-1:0] * mag_y[Q_W-1:0];
  assign sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
  assign is_short = (mag_x[COORD_W:Q_W] == '0) && (mag_y[COORD_W:Q_W] == '0) &&
                    !sq_sum[2*Q_W];

  always_comb begin
    item.slot        = slot_i;
    item.a_x         = a_x_i;
    item.a_y         = a_y_i;
    item.b_x         = b_x_i;
    item.b_y         = b_y_i;
    item.left_child  = left_child_i;
    item.right_child = right_child_i;
    item.leaf_line   = leaf_line_i;
    item.w_x         = w_x;
    item.w_y         = w_y;
    item.kind        = KIND_QUERY;
    keep             = 1'b0;
    unique case (mode)
      MODE_NODE: begin
        item.kind = KIND_NODE;
        keep      = (32'(slot_i) < MAX_NODES);
      end
      MODE_SEG: begin
        item.kind = KIND_SEG;
        keep      = (32'(slot_i) < MAX_LINES);
      end
      MODE_QUERY: begin
        item.kind = is_short ? KIND_SHORT : KIND_QUERY;
        keep      = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full_o    = (fill_q == QFILL_W'(QD));
  assign accept    = push_i && !full_o;
  assign enq       = accept && keep;
  assign q_valid_o = (fill_q != '0);
  assign deq       = q_ready_i && q_valid_o;
  assign q_item_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (enq) wptr_q <= wptr_q + 1'b1;
      if (deq) rptr_q <= rptr_q + 1'b1;
      if (enq && !deq) begin
        fill_q <= fill_q + 1'b1;
      end else if (deq && !enq) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wptr_q] <= item;
    end
  end

endmodule

### rtl/aabb_back.sv
// ----------------------------------------------------------------------------
// aabb_back: traversal engine of the query block
// Performs table writes, walks the box tree with a bounded stack, tests boxes
// and segments with a shared multiplier and a bit-serial divider, and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module aabb_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  aabb_pkg::item_t                   q_item_i,
  output logic                              q_ready_o,
  input  logic                              cfg_we_i,
  input  logic [aabb_pkg::IDX_W-1:0]        cfg_root_i,
  output logic                              out_valid_o,
  input  logic                              out_pop_i,
  output logic [aabb_pkg::FRAC_W-1:0]       out_hit_o,
  output logic                              out_ovf_o
);
  import aabb_pkg::*;

  back_state_e             state_q, state_d;
  logic [IDX_W-1:0]        root_q;
  logic [IDX_W-1:0]        stack_q [STACK_DEPTH];
  logic [SP_W-1:0]         pos_q, top_ptr;
  logic [VIS_W-1:0]        visits_q;
  logic                    busy_q;
  logic [PIDX_W-1:0]       pidx_q;
  logic [QCNT_W-1:0]       cnt_q;
  logic                    out_valid_q, out_ovf_q;
  logic [FRAC_W-1:0]       out_hit_q;

  logic signed [COORD_W-1:0] sx_q, sy_q;
  logic signed [COORD_W:0]   sum_x_q, sum_y_q;
  logic signed [OPW-1:0]     wx_q, wy_q, awx_q, awy_q;
  logic signed [OPW-1:0]     r_cx_q, r_cy_q, r_hx_q, r_hy_q;
  logic signed [PW-1:0]      prod_q [NPROD];
  logic signed [PW-1:0]      den_q, u_q, t_q;
  logic [REM_W-1:0]          rem_q;
  logic [Q_W-1:0]            quo_q;
  logic [FRAC_W-1:0]         hit_q;
  logic                      ovf_q;

  logic [NODE_DW-1:0]        node_rdata;
  logic [SEG_DW-1:0]         seg_rdata;
  logic                      node_we, node_re, seg_we, seg_re;
  logic [IDX_W-1:0]          top_node;
  logic signed [COORD_W-1:0] n_l, n_t, n_r, n_b, s_ox, s_oy, s_dx, s_dy;
  logic [IDX_W-1:0]          n_left, n_right;
  logic signed [IDX_W-1:0]   n_line;
  logic                      visit_stop, node_bad, axis_miss, box_hit, is_leaf, line_ok;
  logic                      stack_full, seg_fail, div_ge, out_free, last_prod;
  logic signed [OPW:0]       acx, acy, limx, limy;
  logic signed [PW-1:0]      lhs, lhs_abs, rhs, dn, un, tn;
  logic [REM_W-1:0]          rem_sh, den_u, rem_next;
  logic [Q_W-1:0]            quo_next;
  mul_req_t                  mreq;
  mul_rsp_t                  mrsp;
  logic signed [OPW-1:0]     wx_n, wy_n;

  aabb_ram #(.WIDTH(NODE_DW), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .waddr_i (NODE_AW'(q_item_i.slot)),
    .wdata_i ({q_item_i.a_x, q_item_i.a_y, q_item_i.b_x, q_item_i.b_y,
               q_item_i.left_child, q_item_i.right_child, q_item_i.leaf_line}),
    .re_i    (node_re),
    .raddr_i (NODE_AW'(top_node)),
    .rdata_o (node_rdata)
  );

  aabb_ram #(.WIDTH(SEG_DW), .DEPTH(MAX_LINES)) u_seg_ram (
    .clk_i   (clk_i),
    .we_i    (seg_we),
    .waddr_i (LINE_AW'(q_item_i.slot)),
    .wdata_i ({q_item_i.a_x, q_item_i.a_y, q_item_i.b_x, q_item_i.b_y}),
    .re_i    (seg_re),
    .raddr_i (LINE_AW'(n_line)),
    .rdata_o (seg_rdata)
  );

  aabb_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  assign {n_l, n_t, n_r, n_b, n_left, n_right, n_line} = node_rdata;
  assign {s_ox, s_oy, s_dx, s_dy} = seg_rdata;

  assign top_ptr    = pos_q - 1'b1;
  assign top_node   = stack_q[top_ptr[STK_AW-1:0]];
  assign visit_stop = (visits_q >= VIS_W'(VISIT_LIMIT));
  assign node_bad   = (32'(top_node) >= MAX_NODES);
  assign stack_full = (pos_q == SP_W'(STACK_DEPTH));
  assign out_free   = !out_valid_q || out_pop_i;
  assign last_prod  = (state_q == BK_BOX_MUL) ? (pidx_q == PIDX_W'(3))
                                              : (pidx_q == PIDX_W'(NPROD - 1));

  // Axis tests on the box extents.
  assign acx  = r_cx_q[OPW-1] ? -(OPW+1)'(r_cx_q) : (OPW+1)'(r_cx_q);
  assign acy  = r_cy_q[OPW-1] ? -(OPW+1)'(r_cy_q) : (OPW+1)'(r_cy_q);
  assign limx = (OPW+1)'(awx_q) + (OPW+1)'(r_hx_q);
  assign limy = (OPW+1)'(awy_q) + (OPW+1)'(r_hy_q);
  assign axis_miss = (acx > limx) || (acy > limy);

  // Cross-product test against the ray direction.
  assign lhs     = prod_q[0] - prod_q[1];
  assign lhs_abs = lhs[PW-1] ? -lhs : lhs;
  assign rhs     = prod_q[2] + prod_q[3];
  assign box_hit = !(rhs < lhs_abs);
  assign is_leaf = (n_line != NO_LINE);
  assign line_ok = !n_line[IDX_W-1] && (32'(n_line) < MAX_LINES);

  // Segment intersection checks after normalizing the sign of the denominator.
  assign dn = den_q[PW-1] ? -den_q : den_q;
  assign un = den_q[PW-1] ? -u_q   : u_q;
  assign tn = den_q[PW-1] ? -t_q   : t_q;
  assign seg_fail = (den_q == '0) || un[PW-1] || (dn < un) ||
                    tn[PW-1] || (tn == '0) || !(tn < dn);

  assign rem_sh   = {rem_q[REM_W-2:0], 1'b0};
  assign den_u    = REM_W'($unsigned(den_q));
  assign div_ge   = (rem_sh >= den_u);
  assign rem_next = div_ge ? rem_sh - den_u : rem_sh;
  assign quo_next = {quo_q[Q_W-2:0], div_ge};

  assign wx_n = -wx_q;
  assign wy_n = -wy_q;

  always_comb begin
    mreq.a = r_cx_q;
    mreq.b = wy_q;
    if (state_q == BK_BOX_MUL) begin
      case (pidx_q)
        PIDX_W'(0): begin mreq.a = r_cx_q; mreq.b = wy_q;  end
        PIDX_W'(1): begin mreq.a = r_cy_q; mreq.b = wx_q;  end
        PIDX_W'(2): begin mreq.a = r_hx_q; mreq.b = awy_q; end
        default:    begin mreq.a = r_hy_q; mreq.b = awx_q; end
      endcase
    end else begin
      case (pidx_q)
        PIDX_W'(0): begin mreq.a = wx_q;   mreq.b = r_hy_q; end
        PIDX_W'(1): begin mreq.a = wy_q;   mreq.b = r_hx_q; end
        PIDX_W'(2): begin mreq.a = r_cx_q; mreq.b = wy_q;   end
        PIDX_W'(3): begin mreq.a = r_cy_q; mreq.b = wx_q;   end
        PIDX_W'(4): begin mreq.a = r_cx_q; mreq.b = r_hy_q; end
        default:    begin mreq.a = r_cy_q; mreq.b = r_hx_q; end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.kind == KIND_QUERY) begin
            state_d = BK_NODE_RD;
          end else if (q_item_i.kind == KIND_SHORT) begin
            state_d = BK_RESULT;
          end
        end
      end
      BK_NODE_RD: begin
        if (visit_stop) begin
          state_d = BK_RESULT;
        end else if (node_bad) begin
          state_d = BK_POP;
        end else begin
          state_d = BK_BOX_AXIS;
        end
      end
      BK_BOX_AXIS: state_d = BK_BOX_CMP;
      BK_BOX_CMP:  state_d = axis_miss ? BK_POP : BK_BOX_MUL;
      BK_BOX_MUL:  if (mrsp.done && last_prod) state_d = BK_BOX_DEC;
      BK_BOX_DEC: begin
        if (!box_hit) begin
          state_d = BK_POP;
        end else if (is_leaf) begin
          state_d = line_ok ? BK_SEG_PREP : BK_POP;
        end else if (stack_full) begin
          state_d = BK_POP;
        end else begin
          state_d = BK_NODE_RD;
        end
      end
      BK_SEG_PREP: state_d = BK_SEG_MUL;
      BK_SEG_MUL:  if (mrsp.done && last_prod) state_d = BK_SEG_SUB;
      BK_SEG_SUB:  state_d = BK_SEG_CHK;
      BK_SEG_CHK:  state_d = seg_fail ? BK_POP : BK_DIV;
      BK_DIV:      if (cnt_q == QCNT_W'(Q_W - 1)) state_d = BK_POP;
      BK_POP:      state_d = (pos_q == SP_W'(1)) ? BK_RESULT : BK_NODE_RD;
      BK_RESULT:   if (out_free) state_d = BK_IDLE;
      default:     state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o  = (state_q == BK_IDLE);
    node_we    = (state_q == BK_IDLE) && q_valid_i && (q_item_i.kind == KIND_NODE);
    seg_we     = (state_q == BK_IDLE) && q_valid_i && (q_item_i.kind == KIND_SEG);
    node_re    = (state_q == BK_NODE_RD) && !visit_stop && !node_bad;
    seg_re     = (state_q == BK_BOX_DEC) && box_hit && is_leaf && line_ok;
    mreq.start = ((state_q == BK_BOX_MUL) || (state_q == BK_SEG_MUL)) && !busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      root_q      <= '0;
      pos_q       <= '0;
      visits_q    <= '0;
      busy_q      <= 1'b0;
      pidx_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) root_q <= cfg_root_i;
      if (out_pop_i) out_valid_q <= 1'b0;
      case (state_q)
        BK_IDLE: begin
          pos_q    <= SP_W'(1);
          visits_q <= '0;
        end
        BK_NODE_RD: if (!visit_stop) visits_q <= visits_q + 1'b1;
        BK_BOX_MUL, BK_SEG_MUL: begin
          if (mreq.start) busy_q <= 1'b1;
          if (mrsp.done) begin
            busy_q <= 1'b0;
            pidx_q <= last_prod ? '0 : pidx_q + 1'b1;
          end
        end
        BK_BOX_DEC: if (box_hit && !is_leaf && !stack_full) pos_q <= pos_q + 1'b1;
        BK_SEG_CHK: cnt_q <= '0;
        BK_DIV:     cnt_q <= cnt_q + 1'b1;
        BK_POP:     pos_q <= pos_q - 1'b1;
        BK_RESULT:  if (out_free) out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          stack_q[0] <= root_q;
          sx_q    <= q_item_i.a_x;
          sy_q    <= q_item_i.a_y;
          sum_x_q <= $signed({q_item_i.a_x[COORD_W-1], q_item_i.a_x}) +
                     $signed({q_item_i.b_x[COORD_W-1], q_item_i.b_x});
          sum_y_q <= $signed({q_item_i.a_y[COORD_W-1], q_item_i.a_y}) +
                     $signed({q_item_i.b_y[COORD_W-1], q_item_i.b_y});
          wx_q    <= OPW'(q_item_i.w_x);
          wy_q    <= OPW'(q_item_i.w_y);
          hit_q   <= NO_HIT;
          ovf_q   <= 1'b0;
        end
      end
      BK_NODE_RD: begin
        awx_q <= wx_q[OPW-1] ? wx_n : wx_q;
        awy_q <= wy_q[OPW-1] ? wy_n : wy_q;
        if (visit_stop) ovf_q <= 1'b1;
      end
      BK_BOX_AXIS: begin
        r_cx_q <= OPW'(sum_x_q) - (OPW'(n_l) + OPW'(n_r));
        r_cy_q <= OPW'(sum_y_q) - (OPW'(n_t) + OPW'(n_b));
        r_hx_q <= OPW'(n_r) - OPW'(n_l);
        r_hy_q <= OPW'(n_b) - OPW'(n_t);
      end
      BK_BOX_MUL, BK_SEG_MUL: if (mrsp.done) prod_q[pidx_q] <= mrsp.p;
      BK_BOX_DEC: begin
        if (box_hit && !is_leaf) begin
          if (stack_full) begin
            ovf_q <= 1'b1;
          end else begin
            stack_q[top_ptr[STK_AW-1:0]] <= n_left;
            stack_q[pos_q[STK_AW-1:0]]   <= n_right;
          end
        end
      end
      BK_SEG_PREP: begin
        r_cx_q <= OPW'(s_ox) - OPW'(sx_q);
        r_cy_q <= OPW'(s_oy) - OPW'(sy_q);
        r_hx_q <= OPW'(s_dx);
        r_hy_q <= OPW'(s_dy);
      end
      BK_SEG_SUB: begin
        den_q <= prod_q[0] - prod_q[1];
        u_q   <= prod_q[2] - prod_q[3];
        t_q   <= prod_q[4] - prod_q[5];
      end
      BK_SEG_CHK: begin
        den_q <= dn;
        rem_q <= REM_W'($unsigned(tn));
        quo_q <= '0;
      end
      BK_DIV: begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        if ((cnt_q == QCNT_W'(Q_W - 1)) && ({1'b0, quo_next} < hit_q)) begin
          hit_q <= {1'b0, quo_next};
        end
      end
      BK_RESULT: begin
        if (out_free) begin
          out_hit_q <= hit_q;
          out_ovf_q <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

### rtl/aabb_tree_ray_segment_test.sv
// ----------------------------------------------------------------------------
// aabb_tree_ray_segment_test: 2D ray query over a stored bounding-box tree
// Node and segment tables are loaded through the input queue; a ray query
// walks the tree and returns the nearest hit fraction.
// ----------------------------------------------------------------------------
// Usage: the input side is a queue port. A transaction is taken when push is
// high and full is low; mode selects a node write, a segment write or a ray
// query. Writes produce no result. Every query produces one result, shown on
// hit_fraction_o and stack_overflow_o while empty is low and removed by pop.
// root_index_i is loaded when root_index_we_i is high; the user must write it
// only while idle, as the block itself does not enforce this. A write passes
// through the front queue to the engine. A query of a ray shorter than one
// unit goes straight to the result. Otherwise each visited node takes four
// products of the shared multiplier, and each reached leaf six more products
// plus a 16-step divider. Queries are served one at a time.
// Reset clears the queues and the root register; the node and segment tables
// are not cleared and must be written before use. When the result is not
// popped, the engine holds the next result and the front queue fills, then
// full rises.
// ----------------------------------------------------------------------------
module aabb_tree_ray_segment_test (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [aabb_pkg::MODE_W-1:0]         mode_i,
  input  logic [aabb_pkg::IDX_W-1:0]          slot_i,
  input  logic signed [aabb_pkg::COORD_W-1:0] a_x_i,
  input  logic signed [aabb_pkg::COORD_W-1:0] a_y_i,
  input  logic signed [aabb_pkg::COORD_W-1:0] b_x_i,
  input  logic signed [aabb_pkg::COORD_W-1:0] b_y_i,
  input  logic [aabb_pkg::IDX_W-1:0]          left_child_i,
  input  logic [aabb_pkg::IDX_W-1:0]          right_child_i,
  input  logic signed [aabb_pkg::IDX_W-1:0]   leaf_line_i,
  input  logic                                root_index_we_i,
  input  logic [aabb_pkg::IDX_W-1:0]          root_index_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [aabb_pkg::FRAC_W-1:0]         hit_fraction_o,
  output logic                                stack_overflow_o
);
  import aabb_pkg::*;

  item_t q_item;
  logic  q_valid, q_ready, out_valid;

  aabb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .mode_i        (mode_i),
    .slot_i        (slot_i),
    .a_x_i         (a_x_i),
    .a_y_i         (a_y_i),
    .b_x_i         (b_x_i),
    .b_y_i         (b_y_i),
    .left_child_i  (left_child_i),
    .right_child_i (right_child_i),
    .leaf_line_i   (leaf_line_i),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item),
    .q_ready_i     (q_ready)
  );

  aabb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_ready_o   (q_ready),
    .cfg_we_i    (root_index_we_i),
    .cfg_root_i  (root_index_i),
    .out_valid_o (out_valid),
    .out_pop_i   (pop && out_valid),
    .out_hit_o   (hit_fraction_o),
    .out_ovf_o   (stack_overflow_o)
  );

  assign empty = !out_valid;

endmodule

### rtl/aabb_chk.sv
// ----------------------------------------------------------------------------
// aabb_chk: port checker for the ray query block
// Watches the result queue port and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module aabb_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [aabb_pkg::FRAC_W-1:0] hit_fraction_o,
  input logic                        stack_overflow_o
);
  import aabb_pkg::*;

  // A waiting result stays until it is popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result transaction withdrawn before pop");

  // A waiting result does not change.
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(hit_fraction_o) && $stable(stack_overflow_o)))
    else $error("result changed while waiting");

  // A waiting hit fraction never exceeds the no-hit value.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (hit_fraction_o <= NO_HIT))
    else $error("hit fraction out of range");

  // Leaving reset, no result waits and the input side is open.
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

bind aabb_tree_ray_segment_test aabb_chk u_chk (.*);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Ray query tree testbench
// Loads node and segment tables, casts rays and checks every result against
// a predictor that walks the same tree with exact wide integer arithmetic.
// Directed tests cover the named corner cases, then random trees and rays.
// ----------------------------------------------------------------------------
module testbench;
  import aabb_pkg::*;

  localparam int U = 65536;
  localparam int WATCHDOG_LIMIT = 8000000;
  localparam int ITEM_TARGET = 1400;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    mode_e                    mode;
    logic [IDX_W-1:0]         slot;
    logic signed [31:0]       ax, ay, bx, by;
    logic [IDX_W-1:0]         lc, rc;
    logic signed [IDX_W-1:0]  ll;
  } item_s;

  typedef struct {
    logic [FRAC_W-1:0] frac;
    logic              ovf;
  } answer_s;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [MODE_W-1:0] mode_r = '0;
  logic [IDX_W-1:0] slot_r = '0, lc_r = '0, rc_r = '0, ll_r = '0;
  logic signed [31:0] ax_r = '0, ay_r = '0, bx_r = '0, by_r = '0;
  logic root_we = 1'b0;
  logic [IDX_W-1:0] root_r = '0;
  logic empty;
  logic pop = 1'b0;
  logic [FRAC_W-1:0] hit_fraction;
  logic stack_overflow;

  int node_l[MAX_NODES], node_t[MAX_NODES], node_r[MAX_NODES], node_b[MAX_NODES];
  logic [IDX_W-1:0] node_lc[MAX_NODES], node_rc[MAX_NODES];
  logic signed [IDX_W-1:0] node_ll[MAX_NODES];
  int seg_x[MAX_LINES], seg_y[MAX_LINES], seg_dx[MAX_LINES], seg_dy[MAX_LINES];
  logic [IDX_W-1:0] root_model = '0;

  answer_s pending_hits[$];
  int n_items = 0, n_results = 0, n_hits = 0, n_ovf = 0, n_errors = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  aabb_tree_ray_segment_test i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .mode_i          (mode_r),
    .slot_i          (slot_r),
    .a_x_i           (ax_r),
    .a_y_i           (ay_r),
    .b_x_i           (bx_r),
    .b_y_i           (by_r),
    .left_child_i    (lc_r),
    .right_child_i   (rc_r),
    .leaf_line_i     (ll_r),
    .root_index_we_i (root_we),
    .root_index_i    (root_r),
    .empty           (empty),
    .pop             (pop),
    .hit_fraction_o  (hit_fraction),
    .stack_overflow_o(stack_overflow)
  );

  function automatic wide_t wabs(wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit box_touched(wide_t sx, wide_t sy, wide_t ex, wide_t ey, int n);
    wide_t l, t, r, b, cx, cy, wx, wy, hx, hy, lhs, rhs;
    l = node_l[n]; t = node_t[n]; r = node_r[n]; b = node_b[n];
    cx = sx + ex - (l + r); cy = sy + ey - (t + b);
    wx = ex - sx; wy = ey - sy;
    hx = r - l; hy = b - t;
    if (wabs(cx) > wabs(wx) + hx || wabs(cy) > wabs(wy) + hy) return 1'b0;
    lhs = wabs(cx * wy - cy * wx);
    rhs = hx * wabs(wy) + hy * wabs(wx);
    return !(rhs < lhs);
  endfunction

  function automatic logic [FRAC_W-1:0] seg_fraction(wide_t sx, wide_t sy, wide_t ex,
                                                     wide_t ey, int k);
    wide_t wx, wy, px, py, dx, dy, den, u, t, q;
    wx = ex - sx; wy = ey - sy;
    px = wide_t'(seg_x[k]) - sx; py = wide_t'(seg_y[k]) - sy;
    dx = seg_dx[k]; dy = seg_dy[k];
    den = wx * dy - wy * dx;
    u = px * wy - py * wx;
    t = px * dy - py * dx;
    if (den == 0) return NO_HIT;
    if (den < 0) begin
      den = -den; u = -u; t = -t;
    end
    if (u < 0 || u > den) return NO_HIT;
    if (t <= 0 || t >= den) return NO_HIT;
    q = (t <<< 16) / den;
    return q[FRAC_W-1:0];
  endfunction

  function automatic answer_s ray_hit_predict(logic signed [31:0] ax, logic signed [31:0] ay,
                                              logic signed [31:0] bx, logic signed [31:0] by);
    answer_s res;
    wide_t sx, sy, ex, ey, wx, wy;
    int stk[STACK_DEPTH];
    int pos, n, visits;
    bit stop;
    logic [FRAC_W-1:0] f;
    sx = ax; sy = ay; ex = bx; ey = by;
    wx = ex - sx; wy = ey - sy;
    res.frac = NO_HIT;
    res.ovf = 1'b0;
    if (wabs(wx) < U && wabs(wy) < U && wx * wx + wy * wy < (wide_t'(1) <<< 32)) return res;
    stk[0] = root_model;
    pos = 1; visits = 0; stop = 1'b0;
    while (pos > 0 && !stop) begin
      n = stk[pos-1];
      if (visits >= VISIT_LIMIT) begin
        res.ovf = 1'b1;
        stop = 1'b1;
      end else begin
        visits++;
        if (!box_touched(sx, sy, ex, ey, n)) begin
          pos--;
        end else if (node_ll[n] != -1) begin
          if (node_ll[n] >= 0) begin
            f = seg_fraction(sx, sy, ex, ey, node_ll[n]);
            if (f < res.frac) res.frac = f;
          end
          pos--;
        end else if (pos == STACK_DEPTH) begin
          pos--;
          res.ovf = 1'b1;
        end else begin
          stk[pos-1] = node_lc[n];
          stk[pos] = node_rc[n];
          pos++;
        end
      end
    end
    return res;
  endfunction

  task automatic send_item(input item_s it);
    while (!no_idle && $urandom_range(99) < 31) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    mode_r <= it.mode; slot_r <= it.slot;
    ax_r <= it.ax; ay_r <= it.ay; bx_r <= it.bx; by_r <= it.by;
    lc_r <= it.lc; rc_r <= it.rc; ll_r <= it.ll;
    do @(posedge clk); while (full);
    n_items++;
    case (it.mode)
      MODE_NODE: begin
        node_l[it.slot] = it.ax; node_t[it.slot] = it.ay;
        node_r[it.slot] = it.bx; node_b[it.slot] = it.by;
        node_lc[it.slot] = it.lc; node_rc[it.slot] = it.rc; node_ll[it.slot] = it.ll;
      end
      MODE_SEG: begin
        if (it.slot < MAX_LINES) begin
          seg_x[it.slot] = it.ax; seg_y[it.slot] = it.ay;
          seg_dx[it.slot] = it.bx; seg_dy[it.slot] = it.by;
        end
      end
      MODE_QUERY: pending_hits.push_back(ray_hit_predict(it.ax, it.ay, it.bx, it.by));
      default: ;
    endcase
  endtask

  function automatic item_s noise_item(mode_e m);
    item_s it;
    it.mode = m; it.slot = $urandom;
    it.ax = $urandom; it.ay = $urandom; it.bx = $urandom; it.by = $urandom;
    it.lc = $urandom; it.rc = $urandom; it.ll = $urandom;
    return it;
  endfunction

  task automatic write_seg(input int slot, input int x, input int y, input int dx, input int dy);
    item_s it;
    it = noise_item(MODE_SEG);
    it.slot = slot; it.ax = x; it.ay = y; it.bx = dx; it.by = dy;
    send_item(it);
  endtask

  task automatic write_node(input int slot, input int l, input int t, input int r, input int b,
                            input int lc, input int rc, input int ll);
    item_s it;
    it = noise_item(MODE_NODE);
    it.slot = slot; it.ax = l; it.ay = t; it.bx = r; it.by = b;
    it.lc = lc; it.rc = rc; it.ll = ll;
    send_item(it);
  endtask

  task automatic cast_ray(input int ax, input int ay, input int bx, input int by);
    item_s it;
    it = noise_item(MODE_QUERY);
    it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
    send_item(it);
  endtask

  task automatic settle_and_set_root(input int root);
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    root_we <= 1'b1;
    root_r <= root;
    @(posedge clk);
    root_we <= 1'b0;
    root_model = root;
  endtask

  task automatic test_corner_cases();
    write_seg(0, 10 * U, -5 * U, 0, 10 * U);
    write_seg(8191, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h80000000);
    write_seg(12000, 3 * U, 3 * U, U, U);
    write_node(0, -100 * U, -100 * U, 100 * U, 100 * U, 16383, 0, 0);
    write_node(1, 100 * U, 100 * U, -100 * U, -100 * U, 0, 16383, 0);
    write_node(2, -100 * U, -100 * U, 100 * U, 100 * U, 0, 0, -5);
    write_node(16383, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 1, -1);
    send_item(noise_item(MODE_NONE));
    cast_ray(0, 0, 20 * U, 0);
    cast_ray(0, 0, U / 2, 0);
    cast_ray(0, 0, 0, 20 * U);
    cast_ray(10 * U - 1, 0, 32'h7fffffff, 0);
    cast_ray(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    cast_ray(20 * U, 0, 0, 0);
    settle_and_set_root(1);
    cast_ray(0, 0, 20 * U, 0);
    settle_and_set_root(2);
    cast_ray(0, 0, 20 * U, 0);
    settle_and_set_root(16383);
    cast_ray(0, 0, 20 * U, U);
    cast_ray(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
  endtask

  task automatic test_full_stack();
    write_node(99, -1000 * U, -1000 * U, 1000 * U, 1000 * U, 0, 0, 0);
    for (int i = 100; i < 140; i++)
      write_node(i, -1000 * U, -1000 * U, 1000 * U, 1000 * U, 99, i + 1, (i == 139) ? 0 : -1);
    settle_and_set_root(100);
    cast_ray(0, 0, 20 * U, 0);
  endtask

  task automatic test_runaway_walk();
    write_node(200, -1000 * U, -1000 * U, 1000 * U, 1000 * U, 200, 200, -1);
    settle_and_set_root(200);
    cast_ray(0, 0, 20 * U, U);
  endtask

  function automatic int near_coord(int span);
    return $urandom_range(0, 2 * span * U) - span * U;
  endfunction

  task automatic test_random_trees();
    int seg_slots[$], work[$];
    int bl[16], bt[16], br[16], bb[16], slot_of[16];
    int base, nseg, nleaf, cnt, k, a, b, pad, ax, ay, bx, by, nq, round;
    round = 0;
    while (n_items < ITEM_TARGET) begin
      no_idle = (round >= 40 && round < 60);
      seg_slots.delete();
      work.delete();
      nseg = $urandom_range(1, 6);
      for (int i = 0; i < nseg; i++) begin
        k = (i == 0) ? $urandom_range(0, MAX_LINES - 1) : $urandom_range(0, 16383);
        write_seg(k, near_coord(64), near_coord(64), near_coord(32), near_coord(32));
        if (k < MAX_LINES) seg_slots.push_back(k);
      end
      base = $urandom_range(0, 16383 - 16);
      nleaf = $urandom_range(1, 8);
      cnt = 0;
      for (int i = 0; i < nleaf; i++) begin
        k = seg_slots[$urandom_range(0, seg_slots.size() - 1)];
        pad = $urandom_range(0, 2 * U);
        bl[cnt] = ((seg_dx[k] < 0) ? seg_x[k] + seg_dx[k] : seg_x[k]) - pad;
        br[cnt] = ((seg_dx[k] < 0) ? seg_x[k] : seg_x[k] + seg_dx[k]) + pad;
        bt[cnt] = ((seg_dy[k] < 0) ? seg_y[k] + seg_dy[k] : seg_y[k]) - pad;
        bb[cnt] = ((seg_dy[k] < 0) ? seg_y[k] : seg_y[k] + seg_dy[k]) + pad;
        if ($urandom_range(99) < 15) begin
          bl[cnt] = near_coord(80); br[cnt] = near_coord(80);
          bt[cnt] = near_coord(80); bb[cnt] = near_coord(80);
        end
        if ($urandom_range(99) < 8) k = -$urandom_range(2, 8192);
        slot_of[cnt] = base + cnt;
        write_node(slot_of[cnt], bl[cnt], bt[cnt], br[cnt], bb[cnt], $urandom, $urandom, k);
        work.push_back(cnt);
        cnt++;
      end
      while (work.size() > 1) begin
        k = $urandom_range(0, work.size() - 1);
        a = work[k]; work.delete(k);
        k = $urandom_range(0, work.size() - 1);
        b = work[k]; work.delete(k);
        bl[cnt] = (bl[a] < bl[b]) ? bl[a] : bl[b];
        bt[cnt] = (bt[a] < bt[b]) ? bt[a] : bt[b];
        br[cnt] = (br[a] > br[b]) ? br[a] : br[b];
        bb[cnt] = (bb[a] > bb[b]) ? bb[a] : bb[b];
        if ($urandom_range(99) < 10) begin
          bl[cnt] = near_coord(80); br[cnt] = near_coord(80);
          bt[cnt] = near_coord(80); bb[cnt] = near_coord(80);
        end
        slot_of[cnt] = base + cnt;
        write_node(slot_of[cnt], bl[cnt], bt[cnt], br[cnt], bb[cnt], slot_of[a], slot_of[b], -1);
        work.push_back(cnt);
        cnt++;
      end
      if ($urandom_range(99) < 30) send_item(noise_item(MODE_NONE));
      if ($urandom_range(99) < 20)
        write_seg($urandom_range(MAX_LINES, 16383), $urandom, $urandom, $urandom, $urandom);
      settle_and_set_root(slot_of[work[0]]);
      nq = $urandom_range(4, 12);
      for (int i = 0; i < nq; i++) begin
        ax = near_coord(80); ay = near_coord(80);
        k = $urandom_range(99);
        if (k < 7) begin
          bx = ax + $urandom_range(0, 90000) - 45000;
          by = ay + $urandom_range(0, 90000) - 45000;
        end else if (k < 12) begin
          ax = $urandom; ay = $urandom; bx = $urandom; by = $urandom;
        end else begin
          bx = near_coord(80); by = near_coord(80);
        end
        cast_ray(ax, ay, bx, by);
      end
      round++;
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    answer_s want;
    if (rst_ni) begin
      if (pop && !empty) begin
        n_results++;
        if (hit_fraction != NO_HIT) n_hits++;
        if (stack_overflow) n_ovf++;
        if (pending_hits.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("ERROR: result with no query pending");
        end else begin
          want = pending_hits.pop_front();
          if (hit_fraction !== want.frac || stack_overflow !== want.ovf) begin
            n_errors++;
            if (n_errors <= 10)
              $display("ERROR: result %0d: fraction %0d overflow %0b, expected %0d / %0b",
                       n_results, hit_fraction, stack_overflow, want.frac, want.ovf);
          end
        end
      end
      pop <= no_idle || ($urandom_range(99) >= 31);
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", pending_hits.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_corner_cases();
    test_full_stack();
    test_runaway_walk();
    settle_and_set_root(0);
    cast_ray(-30 * U, 0, 30 * U, U);
    test_random_trees();
    push <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d transactions; checked %0d query results (%0d hits, %0d overflows).",
             n_items, n_results, n_hits, n_ovf);
    if (n_errors == 0 && pending_hits.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("Mismatches: %0d", n_errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
